### rtl/snfcs_pkg.sv
// shared types, codes and command bytes of the spi nor flash command sequencer
`default_nettype none
package snfcs_pkg;

   localparam int ADDR_BITS_DEFAULT = 24;

   // request codes on the request channel, also the held operation
   typedef enum logic [1:0] {
      REQ_READ    = 2'd0,
      REQ_PROGRAM = 2'd1,
      REQ_ERASE   = 2'd2,
      REQ_RX      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_SHIFT   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_REJECT  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_POLL_CMD = 3'd1,
      PH_POLL_RD  = 3'd2,
      PH_WREN     = 3'd3,
      PH_ADDR     = 3'd4,
      PH_TAIL     = 3'd5
   } phase_type;

   localparam logic [7:0] CMD_READ_STATUS  = 8'h05;
   localparam logic [7:0] STATUS_BUSY_MASK = 8'h01;
   localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
   localparam logic [7:0] CMD_PAGE_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_SECTOR_ERASE = 8'h20;
   localparam logic [7:0] CMD_READ         = 8'h03;
   localparam logic [7:0] DUMMY_BYTE       = 8'hFF;

   typedef struct packed {
      kind_type   out_kind;
      logic [7:0] tx_byte;
      logic [7:0] read_data;
      logic       last_of_run;
   } rsp_item_type;

   // up to two results produced by one accepted transaction
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } step_out_type;

   function automatic rsp_item_type make_item(kind_type kind, logic [7:0] tx,
                                              logic [7:0] rd, logic last);
      rsp_item_type item;
      item.out_kind    = kind;
      item.tx_byte     = tx;
      item.read_data   = rd;
      item.last_of_run = last;
      return item;
   endfunction

endpackage
`default_nettype wire

### rtl/snfcs_if.sv
// request and response channel interfaces of the flash command sequencer
`default_nettype none
interface snfcs_req_if #(
   parameter int ADDR_BITS = snfcs_pkg::ADDR_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [ADDR_BITS-1:0] flash_address;
   logic [7:0]           write_data;
   logic [7:0]           rx_byte;

   modport source (output valid, output req_type, output flash_address,
                   output write_data, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input flash_address,
                   input write_data, input rx_byte, output ready);
endinterface

interface snfcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] tx_byte;
   logic [7:0] read_data;
   logic       last_of_run;

   modport source (output valid, output out_kind, output tx_byte,
                   output read_data, output last_of_run, input ready);
   modport sink   (input valid, input out_kind, input tx_byte,
                   input read_data, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/snfcs_seq.sv
// command sequencer state machine: one transaction in, up to two results out
`default_nettype none
module snfcs_seq #(
   parameter int ADDR_BITS = snfcs_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            req_type,
   input  wire logic [ADDR_BITS-1:0]  flash_address,
   input  wire logic [7:0]            write_data,
   input  wire logic [7:0]            rx_byte,
   output snfcs_pkg::step_out_type    step_out
);

   localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;

   snfcs_pkg::phase_type    phase_ff, phase_in;
   logic [2:0]              byte_index_ff, byte_index_in;
   snfcs_pkg::req_code_type pending_op_ff, pending_op_in;
   logic [ADDR_BITS-1:0]    held_address_ff, held_address_in;
   logic [7:0]              held_data_ff, held_data_in;

   snfcs_pkg::req_code_type req_code;
   logic [ADDR_BYTES*8-1:0] addr_pad;
   logic [7:0]              addr_byte;

   assign req_code = snfcs_pkg::req_code_type'(req_type);
   assign addr_pad = (ADDR_BYTES*8)'(held_address_ff);

   // most significant address byte goes out first
   always_comb begin
      addr_byte = '0;
      for (int b = 0; b < ADDR_BYTES; b++) begin
         if (byte_index_ff == 3'(ADDR_BYTES - 1 - b)) begin
            addr_byte = addr_pad[b*8 +: 8];
         end
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      byte_index_in   = byte_index_ff;
      pending_op_in   = pending_op_ff;
      held_address_in = held_address_ff;
      held_data_in    = held_data_ff;
      step_out        = '0;

      if (accept) begin
         if (req_code != snfcs_pkg::REQ_RX) begin
            if (phase_ff != snfcs_pkg::PH_IDLE) begin
               step_out.count = 2'd1;
               step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_REJECT,
                                                     8'h00, 8'h00, 1'b1);
            end else begin
               pending_op_in   = req_code;
               held_address_in = flash_address;
               held_data_in    = write_data;
               byte_index_in   = 3'd0;
               step_out.count  = 2'd1;
               if (req_code == snfcs_pkg::REQ_READ) begin
                  step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                      snfcs_pkg::CMD_READ, 8'h00, 1'b1);
                  phase_in = snfcs_pkg::PH_ADDR;
               end else begin
                  step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                      snfcs_pkg::CMD_READ_STATUS, 8'h00, 1'b1);
                  phase_in = snfcs_pkg::PH_POLL_CMD;
               end
            end
         end else begin
            unique case (phase_ff)
               snfcs_pkg::PH_POLL_CMD: begin
                  step_out.count = 2'd1;
                  step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                      snfcs_pkg::DUMMY_BYTE, 8'h00, 1'b1);
                  phase_in = snfcs_pkg::PH_POLL_RD;
               end
               snfcs_pkg::PH_POLL_RD: begin
                  // keep polling while the busy bit is set
                  if ((rx_byte & snfcs_pkg::STATUS_BUSY_MASK) != 8'h00) begin
                     step_out.count = 2'd1;
                     step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                         snfcs_pkg::DUMMY_BYTE, 8'h00, 1'b1);
                  end else begin
                     step_out.count  = 2'd2;
                     step_out.first  = snfcs_pkg::make_item(
                                          snfcs_pkg::KIND_RELEASE, 8'h00, 8'h00, 1'b0);
                     step_out.second = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                          snfcs_pkg::CMD_WRITE_ENABLE, 8'h00, 1'b1);
                     phase_in = snfcs_pkg::PH_WREN;
                  end
               end
               snfcs_pkg::PH_WREN: begin
                  step_out.count  = 2'd2;
                  step_out.first  = snfcs_pkg::make_item(snfcs_pkg::KIND_RELEASE,
                                       8'h00, 8'h00, 1'b0);
                  step_out.second = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                       (pending_op_ff == snfcs_pkg::REQ_PROGRAM) ?
                                       snfcs_pkg::CMD_PAGE_PROGRAM :
                                       snfcs_pkg::CMD_SECTOR_ERASE, 8'h00, 1'b1);
                  byte_index_in = 3'd0;
                  phase_in      = snfcs_pkg::PH_ADDR;
               end
               snfcs_pkg::PH_ADDR: begin
                  if (byte_index_ff < 3'(ADDR_BYTES)) begin
                     step_out.count = 2'd1;
                     step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                         addr_byte, 8'h00, 1'b1);
                     byte_index_in  = 3'(byte_index_ff + 3'd1);
                  end else if (pending_op_ff == snfcs_pkg::REQ_PROGRAM) begin
                     step_out.count = 2'd1;
                     step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                         held_data_ff, 8'h00, 1'b1);
                     phase_in = snfcs_pkg::PH_TAIL;
                  end else if (pending_op_ff == snfcs_pkg::REQ_READ) begin
                     step_out.count = 2'd1;
                     step_out.first = snfcs_pkg::make_item(snfcs_pkg::KIND_SHIFT,
                                         snfcs_pkg::DUMMY_BYTE, 8'h00, 1'b1);
                     phase_in = snfcs_pkg::PH_TAIL;
                  end else begin
                     step_out.count  = 2'd2;
                     step_out.first  = snfcs_pkg::make_item(
                                          snfcs_pkg::KIND_RELEASE, 8'h00, 8'h00, 1'b0);
                     step_out.second = snfcs_pkg::make_item(snfcs_pkg::KIND_DONE,
                                          8'h00, 8'h00, 1'b1);
                     phase_in      = snfcs_pkg::PH_IDLE;
                     byte_index_in = 3'd0;
                  end
               end
               snfcs_pkg::PH_TAIL: begin
                  step_out.count  = 2'd2;
                  step_out.first  = snfcs_pkg::make_item(snfcs_pkg::KIND_RELEASE,
                                       8'h00, 8'h00, 1'b0);
                  step_out.second = snfcs_pkg::make_item(snfcs_pkg::KIND_DONE, 8'h00,
                                       (pending_op_ff == snfcs_pkg::REQ_READ) ?
                                       rx_byte : 8'h00, 1'b1);
                  phase_in      = snfcs_pkg::PH_IDLE;
                  byte_index_in = 3'd0;
               end
               default: begin
                  // received byte while idle is dropped
                  phase_in = snfcs_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= snfcs_pkg::PH_IDLE;
         byte_index_ff <= 3'd0;
         pending_op_ff <= snfcs_pkg::REQ_READ;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         pending_op_ff <= pending_op_in;
      end
   end

   always_ff @(posedge clock) begin
      held_address_ff <= held_address_in;
      held_data_ff    <= held_data_in;
   end

   a_pair_starts_with_release: assert property (@(posedge clock) disable iff (reset)
      step_out.count == 2'd2 |-> step_out.first.out_kind == snfcs_pkg::KIND_RELEASE)
      else $error("two-result step does not start with a chip-select release");

   a_reject_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      accept && req_code != snfcs_pkg::REQ_RX && phase_ff != snfcs_pkg::PH_IDLE
      |=> $stable(phase_ff))
      else $error("rejected request changed the sequencer phase");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= 3'(ADDR_BYTES))
      else $error("address byte index ran past the address length");

   a_no_result_without_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |-> step_out.count == 2'd0)
      else $error("result produced without an accepted transaction");

endmodule
`default_nettype wire

### rtl/snfcs_rsp_fifo.sv
// four-entry response queue taking up to two results per cycle
`default_nettype none
module snfcs_rsp_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire snfcs_pkg::step_out_type push,
   output logic                      room_for_two,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output snfcs_pkg::rsp_item_type   out_item
);

   snfcs_pkg::rsp_item_type mem [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid    = count_ff != 3'd0;
   assign out_item     = mem[rd_ptr_ff];
   assign pop          = out_valid && out_ready;
   // ready depends only on registered occupancy
   assign room_for_two = count_ff <= 3'd2;

   always_comb begin
      wr_ptr_in = 2'(wr_ptr_ff + push.count);
      rd_ptr_in = 2'(rd_ptr_ff + {1'b0, pop});
      count_in  = 3'(count_ff + {1'b0, push.count} - {2'b00, pop});
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[2'(wr_ptr_ff + 2'd1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("response queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room_for_two)
      else $error("results pushed without room for two");

   a_ptr_gap_matches_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != 3'd4 |-> 2'(wr_ptr_ff - rd_ptr_ff) == count_ff[1:0])
      else $error("queue pointers disagree with occupancy");

endmodule
`default_nettype wire

### rtl/spi_nor_flash_command_sequencer_top.sv
// top level of the spi nor flash command sequencer
//
// req channel: one transaction is a read, program or erase request with its
// address and data, or the byte received for the previous spi transfer.
// rsp channel: one transaction per spi step: shift tx_byte with chip select
// low, release chip select, done (read_data holds the byte read) or rejected.
// last_of_run marks the final result caused by one request transaction.
// A request accepted while a command is in flight is rejected; a received
// byte while idle gives no result.
// The results of a transaction are written into a four-entry response queue
// and offered on the rsp channel from there.
// One req transaction per cycle when each yields one result and rsp.ready
// stays high; a transaction that yields two (chip select release plus next
// step) fills the queue faster than the single rsp port drains it.
// req.ready is high whenever the queue has room for two results, so a stalled
// rsp receiver holds off new requests after at most three queued transactions.
// Reset clears the sequencer to idle and empties the queue.
`default_nettype none
module spi_nor_flash_command_sequencer_top #(
   parameter int ADDR_BITS = snfcs_pkg::ADDR_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   snfcs_req_if.sink req,
   snfcs_rsp_if.source rsp
);

   snfcs_pkg::step_out_type step_out;
   snfcs_pkg::rsp_item_type rsp_item;
   logic                    room_for_two;
   logic                    req_accept;
   logic [ADDR_BITS-1:0]    req_address;

   assign req.ready   = room_for_two;
   assign req_accept  = req.valid && room_for_two;
   assign req_address = ADDR_BITS'(req.flash_address);

   snfcs_seq #(
      .ADDR_BITS(ADDR_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .req_type      (req.req_type),
      .flash_address (req_address),
      .write_data    (req.write_data),
      .rx_byte       (req.rx_byte),
      .step_out      (step_out)
   );

   snfcs_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (step_out),
      .room_for_two (room_for_two),
      .out_valid    (rsp.valid),
      .out_ready    (rsp.ready),
      .out_item     (rsp_item)
   );

   assign rsp.out_kind    = rsp_item.out_kind;
   assign rsp.tx_byte     = rsp_item.tx_byte;
   assign rsp.read_data   = rsp_item.read_data;
   assign rsp.last_of_run = rsp_item.last_of_run;

endmodule
`default_nettype wire
